[hw/rtl/sal_pkg.sv]
// Shelf atlas allocator: shared types, constants and sequencer states.
// No dependencies; used by the interfaces, the shelf cell row and the top level.
package sal_pkg;

  localparam int unsigned MAX_SHELVES_DEF = 64;

  localparam int unsigned RECT_W  = 15;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned RATIO_W = 19;  // holds 10*h and 7*shelf height

  localparam logic [SIZE_W-1:0] INITIAL_SIZE    = 16'd128;
  localparam logic [SIZE_W-1:0] FIRST_SHELF_TOP = 16'd3;
  localparam logic [SIZE_W-1:0] MAX_ATLAS_RESET = 16'd8192;
  localparam logic [RECT_W-1:0] FAIL_SIZE       = 15'd2;

  // x/10 == (x * 0xCCCD) >> 19, exact for every 16-bit x
  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIT,
    ST_PICK,
    ST_GROW,
    ST_DONE
  } sal_state_e;

  // broadcast to every shelf cell
  typedef struct packed {
    logic               fit_en;
    logic               pick_en;
    logic               alloc_en;
    logic [RECT_W-1:0]  req_w;
    logic [RECT_W-1:0]  req_h;
    logic [RATIO_W-1:0] req_h10;
    logic [SIZE_W-1:0]  atlas_w;
    logic [SIZE_W-1:0]  new_top;
    logic [SIZE_W-1:0]  new_height;
  } sal_cmd_t;

  // first-fit result gathered from the cell row
  typedef struct packed {
    logic              hit_any;
    logic [SIZE_W-1:0] sel_top;
    logic [SIZE_W-1:0] sel_used;
  } sal_hit_t;

endpackage

[hw/rtl/sal_if.sv]
// Shelf atlas allocator: valid/ready channel interfaces (request, placement, config).
// Depends on sal_pkg for field widths.
interface sal_rect_if;
  logic                      valid;
  logic                      ready;
  logic [sal_pkg::RECT_W-1:0] rect_width;
  logic [sal_pkg::RECT_W-1:0] rect_height;

  modport source (output valid, output rect_width, output rect_height, input ready);
  modport sink   (input valid, input rect_width, input rect_height, output ready);
endinterface

interface sal_place_if;
  logic                       valid;
  logic                       ready;
  logic [sal_pkg::RECT_W-1:0] pos_x;
  logic [sal_pkg::RECT_W-1:0] pos_y;
  logic [sal_pkg::RECT_W-1:0] out_width;
  logic [sal_pkg::RECT_W-1:0] out_height;
  logic                       placed_ok;
  logic [sal_pkg::SIZE_W-1:0] atlas_width;
  logic [sal_pkg::SIZE_W-1:0] atlas_height;

  modport source (output valid, output pos_x, output pos_y, output out_width,
                  output out_height, output placed_ok, output atlas_width,
                  output atlas_height, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input out_width,
                  input out_height, input placed_ok, input atlas_width,
                  input atlas_height, output ready);
endinterface

interface sal_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [sal_pkg::SIZE_W-1:0] max_atlas_size;

  modport source (output valid, output max_atlas_size, input ready);
  modport sink   (input valid, input max_atlas_size, output ready);
endinterface

[hw/rtl/shelf_atlas_allocator_unit.sv]
// Shelf atlas allocator top level: channels, config register, sequencer, atlas growth.
// Depends on sal_pkg, sal_if and sal_shelf_row.
// Steps: request word taken in IDLE, then CALC, FIT, PICK; a shelf hit or a full table goes
//   to DONE, else GROW doubles the atlas as needed (up to 32768), then opens a shelf or fails.
// One request at a time: next request word taken only after DONE loads the placement word;
//   that load waits while the previous word still waits for ready. Reset: no shelves, next
//   shelf top 3, atlas 128x128, max atlas size 8192; shelf cells keep contents, masked by count.
module shelf_atlas_allocator_unit #(
  parameter int unsigned MAX_SHELVES = sal_pkg::MAX_SHELVES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sal_rect_if.sink   rect_i,
  sal_cfg_if.sink    cfg_i,
  sal_place_if.source place_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SHELVES + 1);
  localparam int unsigned SW    = sal_pkg::SIZE_W;
  localparam int unsigned RW    = sal_pkg::RECT_W;

  // ---------------------------------------------------------------- state
  sal_pkg::sal_state_e state_q, state_d;

  logic [SW-1:0]    max_size_q;
  logic [SW-1:0]    atlas_w_q;
  logic [SW-1:0]    atlas_h_q;
  logic [SW-1:0]    next_top_q;
  logic [CNT_W-1:0] shelf_count_q;

  // request held for the whole placement
  logic [RW-1:0]           req_w_q;
  logic [RW-1:0]           req_h_q;
  logic [sal_pkg::RATIO_W-1:0] req_h10_q;
  logic [SW-1:0]           new_height_q;  // h + h/10

  // result of this request before it goes to the output word
  logic          res_ok_q;
  logic [RW-1:0] res_x_q;
  logic [RW-1:0] res_y_q;

  // output word register
  logic          out_valid_q;
  logic [RW-1:0] out_x_q;
  logic [RW-1:0] out_y_q;
  logic [RW-1:0] out_w_q;
  logic [RW-1:0] out_h_q;
  logic          out_ok_q;
  logic [SW-1:0] out_aw_q;
  logic [SW-1:0] out_ah_q;

  // ---------------------------------------------------------------- control
  logic in_ready;
  logic calc_en;
  logic pick_en;
  logic fit_en;
  logic double_en;
  logic alloc_en;
  logic fail_en;
  logic load_out;

  sal_pkg::sal_cmd_t     cmd;
  sal_pkg::sal_hit_t     hit;
  logic [MAX_SHELVES-1:0] sel_vec;

  logic            table_full;
  logic [SW:0]     shelf_bottom;
  logic            need_grow;
  logic            can_grow;
  logic [30:0]     div10_prod;

  assign rect_i.ready = in_ready;
  assign cfg_i.ready  = 1'b1;

  assign table_full   = shelf_count_q == CNT_W'(MAX_SHELVES);
  // new shelf must end strictly above the atlas bottom and be strictly narrower
  assign shelf_bottom = {1'b0, next_top_q} + {1'b0, new_height_q};
  assign need_grow    = (shelf_bottom >= {1'b0, atlas_h_q})
                     || ({1'b0, req_w_q} >= atlas_w_q);
  assign can_grow     = ({atlas_w_q, 1'b0} <= {1'b0, max_size_q})
                     && ({atlas_h_q, 1'b0} <= {1'b0, max_size_q});

  assign div10_prod = req_h_q * sal_pkg::DIV10_MUL;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sal_pkg::ST_IDLE: begin
        if (rect_i.valid) state_d = sal_pkg::ST_CALC;
      end
      sal_pkg::ST_CALC: state_d = sal_pkg::ST_FIT;
      sal_pkg::ST_FIT:  state_d = sal_pkg::ST_PICK;
      sal_pkg::ST_PICK: begin
        if (hit.hit_any || table_full) state_d = sal_pkg::ST_DONE;
        else                           state_d = sal_pkg::ST_GROW;
      end
      sal_pkg::ST_GROW: begin
        if (!need_grow || !can_grow) state_d = sal_pkg::ST_DONE;
      end
      sal_pkg::ST_DONE: begin
        if (!out_valid_q || place_o.ready) state_d = sal_pkg::ST_IDLE;
      end
      default: state_d = sal_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    calc_en   = 1'b0;
    fit_en    = 1'b0;
    pick_en   = 1'b0;
    double_en = 1'b0;
    alloc_en  = 1'b0;
    fail_en   = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      sal_pkg::ST_IDLE: in_ready = 1'b1;
      sal_pkg::ST_CALC: calc_en  = 1'b1;
      sal_pkg::ST_FIT:  fit_en   = 1'b1;
      sal_pkg::ST_PICK: begin
        pick_en = 1'b1;
        fail_en = !hit.hit_any && table_full;
      end
      sal_pkg::ST_GROW: begin
        double_en = need_grow && can_grow;
        alloc_en  = !need_grow;
        fail_en   = need_grow && !can_grow;
      end
      sal_pkg::ST_DONE: load_out = !out_valid_q || place_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sal_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- atlas state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q    <= sal_pkg::MAX_ATLAS_RESET;
      atlas_w_q     <= sal_pkg::INITIAL_SIZE;
      atlas_h_q     <= sal_pkg::INITIAL_SIZE;
      next_top_q    <= sal_pkg::FIRST_SHELF_TOP;
      shelf_count_q <= '0;
    end else begin
      if (cfg_i.valid) max_size_q <= cfg_i.max_atlas_size;
      if (double_en) begin
        atlas_w_q <= {atlas_w_q[SW-2:0], 1'b0};
        atlas_h_q <= {atlas_h_q[SW-2:0], 1'b0};
      end
      if (alloc_en) begin
        next_top_q    <= shelf_bottom[SW-1:0];
        shelf_count_q <= shelf_count_q + CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- request path
  always_ff @(posedge clk_i) begin
    if (in_ready && rect_i.valid) begin
      req_w_q <= rect_i.rect_width;
      req_h_q <= rect_i.rect_height;
    end
    if (calc_en) begin
      req_h10_q    <= {1'b0, req_h_q, 3'b000} + {3'b000, req_h_q, 1'b0};
      new_height_q <= {1'b0, req_h_q}
                    + SW'(div10_prod[30:sal_pkg::DIV10_SHIFT]);
    end
    if (pick_en && hit.hit_any) begin
      res_ok_q <= 1'b1;
      res_x_q  <= hit.sel_used[RW-1:0];
      res_y_q  <= hit.sel_top[RW-1:0];
    end else if (alloc_en) begin
      res_ok_q <= 1'b1;
      res_x_q  <= '0;
      res_y_q  <= next_top_q[RW-1:0];
    end else if (fail_en) begin
      res_ok_q <= 1'b0;
      res_x_q  <= '0;
      res_y_q  <= '0;
    end
  end

  // ---------------------------------------------------------------- shelf cells
  always_comb begin
    cmd.fit_en     = fit_en;
    cmd.pick_en    = pick_en;
    cmd.alloc_en   = alloc_en;
    cmd.req_w      = req_w_q;
    cmd.req_h      = req_h_q;
    cmd.req_h10    = req_h10_q;
    cmd.atlas_w    = atlas_w_q;
    cmd.new_top    = next_top_q;
    cmd.new_height = new_height_q;
  end

  sal_shelf_row #(
    .MAX_SHELVES (MAX_SHELVES),
    .CNT_W       (CNT_W)
  ) u_row (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .shelf_count_i (shelf_count_q),
    .hit_o         (hit),
    .sel_o         (sel_vec)
  );

  // ---------------------------------------------------------------- output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (place_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_x_q  <= res_x_q;
      out_y_q  <= res_y_q;
      out_w_q  <= res_ok_q ? req_w_q : sal_pkg::FAIL_SIZE;
      out_h_q  <= res_ok_q ? req_h_q : sal_pkg::FAIL_SIZE;
      out_ok_q <= res_ok_q;
      out_aw_q <= atlas_w_q;
      out_ah_q <= atlas_h_q;
    end
  end

  assign place_o.valid        = out_valid_q;
  assign place_o.pos_x        = out_x_q;
  assign place_o.pos_y        = out_y_q;
  assign place_o.out_width    = out_w_q;
  assign place_o.out_height   = out_h_q;
  assign place_o.placed_ok    = out_ok_q;
  assign place_o.atlas_width  = out_aw_q;
  assign place_o.atlas_height = out_ah_q;

  // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sel_vec))
    else $error("more than one shelf selected");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shelf_count_q <= CNT_W'(MAX_SHELVES))
    else $error("shelf count beyond table size");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shelf_count_q != $past(shelf_count_q)) |->
      (shelf_count_q == $past(shelf_count_q) + CNT_W'(1)))
    else $error("shelf count moved by more than one");

  a_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    atlas_w_q == atlas_h_q)
    else $error("atlas no longer square");
`endif

endmodule

[hw/rtl/sal_shelf_cell.sv]
// Shelf atlas allocator: one shelf cell (top, height, used width) with its fit test.
// Depends on sal_pkg; chained by sal_shelf_row.
module sal_shelf_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sal_pkg::sal_cmd_t           cmd_i,
  input  logic [CNT_W-1:0]            shelf_count_i,
  input  logic                        hit_i,
  output logic                        hit_o,
  output logic                        sel_o,
  output logic [sal_pkg::SIZE_W-1:0]  top_o,
  output logic [sal_pkg::SIZE_W-1:0]  used_o
);

  logic [sal_pkg::SIZE_W-1:0]  top_q;
  logic [sal_pkg::SIZE_W-1:0]  height_q;
  logic [sal_pkg::SIZE_W-1:0]  used_q;
  logic                        fit_q;
  logic                        active;
  logic                        is_next;
  logic [sal_pkg::RATIO_W-1:0] height_x7;
  logic [sal_pkg::SIZE_W:0]    width_sum;
  logic                        fit_c;

  assign active  = shelf_count_i > CNT_W'(IDX);
  assign is_next = shelf_count_i == CNT_W'(IDX);

  // 7*sh as 8*sh - sh
  assign height_x7 = {height_q, 3'b000} - {3'b000, height_q};
  assign width_sum = {2'b00, cmd_i.req_w} + {1'b0, used_q};

  assign fit_c = active
              && (cmd_i.req_h10 >= height_x7)
              && ({1'b0, cmd_i.req_h} <= height_q)
              && (width_sum <= {1'b0, cmd_i.atlas_w});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q <= 1'b0;
    end else if (cmd_i.fit_en) begin
      fit_q <= fit_c;
    end
  end

  assign sel_o = fit_q & ~hit_i;
  assign hit_o = fit_q | hit_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_en && is_next) begin
      top_q    <= cmd_i.new_top;
      height_q <= cmd_i.new_height;
      used_q   <= {1'b0, cmd_i.req_w};
    end else if (cmd_i.pick_en && sel_o) begin
      used_q   <= width_sum[sal_pkg::SIZE_W-1:0];
    end
  end

  assign top_o  = sel_o ? top_q  : '0;
  assign used_o = sel_o ? used_q : '0;

endmodule

[hw/rtl/sal_shelf_row.sv]
// Shelf atlas allocator: row of shelf cells with first-fit priority chain.
// Depends on sal_pkg and sal_shelf_cell.
module sal_shelf_row #(
  parameter int unsigned MAX_SHELVES = sal_pkg::MAX_SHELVES_DEF,
  parameter int unsigned CNT_W       = $clog2(MAX_SHELVES + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sal_pkg::sal_cmd_t      cmd_i,
  input  logic [CNT_W-1:0]       shelf_count_i,
  output sal_pkg::sal_hit_t      hit_o,
  output logic [MAX_SHELVES-1:0] sel_o
);

  logic [MAX_SHELVES:0]       hit_chain;
  logic [sal_pkg::SIZE_W-1:0] top_sel  [MAX_SHELVES];
  logic [sal_pkg::SIZE_W-1:0] used_sel [MAX_SHELVES];

  assign hit_chain[0] = 1'b0;

  for (genvar g = 0; g < MAX_SHELVES; g++) begin : g_cell
    sal_shelf_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd_i),
      .shelf_count_i (shelf_count_i),
      .hit_i         (hit_chain[g]),
      .hit_o         (hit_chain[g+1]),
      .sel_o         (sel_o[g]),
      .top_o         (top_sel[g]),
      .used_o        (used_sel[g])
    );
  end

  // at most one cell is selected, so an OR gathers its fields
  always_comb begin
    hit_o.hit_any  = hit_chain[MAX_SHELVES];
    hit_o.sel_top  = '0;
    hit_o.sel_used = '0;
    for (int unsigned k = 0; k < MAX_SHELVES; k++) begin
      hit_o.sel_top  = hit_o.sel_top  | top_sel[k];
      hit_o.sel_used = hit_o.sel_used | used_sel[k];
    end
  end

endmodule
